// ----- rtl/core/mct_pkg.sv -----
// Shared types and codes for the multi-channel compare timer.
package mct_pkg;

    // Operation codes of a command word
    typedef enum logic [1:0] {
        OP_TICK         = 2'd0,
        OP_ABS_ONESHOT  = 2'd1,
        OP_REL_ONESHOT  = 2'd2,
        OP_REPEAT       = 2'd3
    } op_t;

    localparam int TICKS_WIDTH   = 32;
    localparam int CHANNEL_WIDTH = 2;
    localparam int MASK_WIDTH    = 4;

    // Command word
    typedef struct packed {
        logic [1:0]             operation;
        logic [TICKS_WIDTH-1:0] ticks;
    } request_t;

    // Result word
    typedef struct packed {
        logic [CHANNEL_WIDTH-1:0] channel;
        logic                     no_resources;
        logic [MASK_WIDTH-1:0]    fired_mask;
    } result_t;

    // Per-channel control from the top level
    typedef struct packed {
        logic tick;
        logic alloc;
        logic absolute;
        logic repeating;
    } chan_ctrl_t;

endpackage

// ----- rtl/core/multi_channel_compare_timer.sv -----
// Top level of the multi-channel compare timer.
//
// A counter advanced by tick words, with NUM_CHANNELS compare channels. A command word
// on request is taken at a rising edge where start is high and busy is low;
// busy stays low, so a word may be given in every cycle.
// A tick word advances the counter by one; every armed channel whose
// compare value equals the new count fires, a repeating channel adds its
// period, a one-shot channel frees itself. Any other word arms the lowest
// free channel (absolute one-shot, relative one-shot or repeating) or
// reports no_resources.
// Each command word yields one result word on result, marked by done for
// exactly one cycle. The result passes through the input register, then the
// result register. Throughput: one word per cycle, set by the single pass of
// compares, priority encoder and adders between the two registers.
// The receiver cannot stall; results are not held.
// Reset clears the counter and frees every channel; no results are pending.
module multi_channel_compare_timer
    import mct_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                    item_valid_reg;
    request_t                item_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [COUNT_WIDTH-1:0]  count_next;
    logic                    done_reg;
    result_t                 result_reg;
    result_t                 result_next;

    logic [COUNT_WIDTH-1:0]  count_inc;
    logic [COUNT_WIDTH-1:0]  ticks_c;
    logic [63:0]             ticks_ext;
    logic [COUNT_WIDTH-1:0]  rel_value;
    logic                    is_tick;
    logic                    is_req;
    logic [NUM_CHANNELS-1:0] in_use;
    logic [NUM_CHANNELS-1:0] fired;
    logic                    found;
    logic [CH_W-1:0]         sel;
    logic [15:0]             fired_ext;
    logic [3:0]              sel_ext;

    assign busy = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // Capture the command word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= request;
        end
    end

    // Decode and shared arithmetic
    assign is_tick   = item_valid_reg && (op_t'(item_reg.operation) == OP_TICK);
    assign is_req    = item_valid_reg && (op_t'(item_reg.operation) != OP_TICK);
    assign ticks_ext = 64'(item_reg.ticks);
    assign ticks_c   = ticks_ext[COUNT_WIDTH-1:0];
    assign count_inc = count_reg + 1'b1;
    assign rel_value = count_reg + ticks_c;
    assign count_next = is_tick ? count_inc : count_reg;

    // Find the lowest free channel
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (!in_use[i])
            begin
                found = 1'b1;
                sel   = CH_W'(i);
            end
        end
    end

    // Channels
    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_chan
        chan_ctrl_t ctrl;

        always_comb
        begin
            ctrl.tick      = is_tick;
            ctrl.alloc     = is_req && found && (sel == CH_W'(g));
            ctrl.absolute  = (op_t'(item_reg.operation) == OP_ABS_ONESHOT);
            ctrl.repeating = (op_t'(item_reg.operation) == OP_REPEAT);
        end

        mct_channel #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_channel (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count_inc (count_inc),
            .ticks     (ticks_c),
            .rel_value (rel_value),
            .in_use    (in_use[g]),
            .fired     (fired[g])
        );
    end

    // Build the result word
    assign fired_ext = 16'(fired);
    assign sel_ext   = 4'(sel);

    always_comb
    begin
        result_next              = '0;
        result_next.fired_mask   = fired_ext[MASK_WIDTH-1:0];
        if (is_req)
        begin
            result_next.no_resources = !found;
            result_next.channel      = found ? sel_ext[CHANNEL_WIDTH-1:0] : '0;
        end
    end

    // Hold counter and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ----- rtl/core/mct_channel.sv -----
// One compare channel: compare value, period and its allocation marks.
module mct_channel
    import mct_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  chan_ctrl_t             ctrl,
    input  logic [COUNT_WIDTH-1:0] count_inc,
    input  logic [COUNT_WIDTH-1:0] ticks,
    input  logic [COUNT_WIDTH-1:0] rel_value,
    output logic                   in_use,
    output logic                   fired
);

    logic                   in_use_reg;
    logic                   in_use_next;
    logic                   repeats_reg;
    logic                   repeats_next;
    logic [COUNT_WIDTH-1:0] compare_reg;
    logic [COUNT_WIDTH-1:0] compare_next;
    logic [COUNT_WIDTH-1:0] period_reg;
    logic [COUNT_WIDTH-1:0] period_next;
    logic                   match;

    // Match against the advanced count
    assign match  = in_use_reg && (compare_reg == count_inc);
    assign fired  = ctrl.tick && match;
    assign in_use = in_use_reg;

    // Reload, free or arm the channel
    always_comb
    begin
        in_use_next  = in_use_reg;
        repeats_next = repeats_reg;
        compare_next = compare_reg;
        period_next  = period_reg;
        if (fired)
        begin
            if (repeats_reg)
            begin
                compare_next = compare_reg + period_reg;
            end
            else
            begin
                in_use_next = 1'b0;
            end
        end
        else if (ctrl.alloc)
        begin
            in_use_next  = 1'b1;
            repeats_next = ctrl.repeating;
            period_next  = ticks;
            compare_next = ctrl.absolute ? ticks : rel_value;
        end
    end

    // Hold allocation marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= 1'b0;
            repeats_reg <= 1'b0;
        end
        else
        begin
            in_use_reg  <= in_use_next;
            repeats_reg <= repeats_next;
        end
    end

    // Hold compare value and period
    always_ff @(posedge clk)
    begin
        compare_reg <= compare_next;
        period_reg  <= period_next;
    end

endmodule

// ----- dv/multi_channel_compare_timer_test.sv -----
// Self-checking testbench of the multi-channel compare timer.
module multi_channel_compare_timer_test
    import mct_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH       = 4;
    localparam int MAX_DELAY    = 24;
    localparam int RANDOM_WORDS = 1880;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    // Predicted timer state
    logic [TICKS_WIDTH-1:0] tmr_count;
    logic [NUM_CH-1:0]      chan_armed;
    logic [NUM_CH-1:0]      chan_repeats;
    logic [TICKS_WIDTH-1:0] chan_period  [NUM_CH];
    logic [TICKS_WIDTH-1:0] chan_compare [NUM_CH];

    result_t expected_results [$];
    result_t oldest_result;
    int      words_accepted;
    int      mismatches;
    int      drain_cycles;

    multi_channel_compare_timer #(
        .NUM_CHANNELS (NUM_CH),
        .COUNT_WIDTH  (TICKS_WIDTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Run the clock at 20 ns
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Advance the predicted timer by one command word
    function automatic result_t timer_step(request_t w);
        result_t r;
        int      sel;
        int      c;
        r   = '0;
        sel = -1;
        if (op_t'(w.operation) == OP_TICK)
        begin
            tmr_count = tmr_count + 1'b1;
            for (c = 0; c < NUM_CH; c++)
            begin
                if (chan_armed[c] && chan_compare[c] == tmr_count)
                begin
                    r.fired_mask[c] = 1'b1;
                    if (chan_repeats[c])
                        chan_compare[c] = chan_compare[c] + chan_period[c];
                    else
                        chan_armed[c] = 1'b0;
                end
            end
        end
        else
        begin
            // Take the lowest free channel
            for (c = NUM_CH - 1; c >= 0; c--)
            begin
                if (!chan_armed[c])
                    sel = c;
            end
            if (sel < 0)
                r.no_resources = 1'b1;
            else
            begin
                chan_armed[sel]   = 1'b1;
                chan_repeats[sel] = (op_t'(w.operation) == OP_REPEAT);
                chan_period[sel]  = w.ticks;
                if (op_t'(w.operation) == OP_ABS_ONESHOT)
                    chan_compare[sel] = w.ticks;
                else
                    chan_compare[sel] = tmr_count + w.ticks;
                r.channel = sel[CHANNEL_WIDTH-1:0];
            end
        end
        return r;
    endfunction

    function automatic int free_channel_count();
        int n;
        int c;
        n = 0;
        for (c = 0; c < NUM_CH; c++)
        begin
            if (!chan_armed[c])
                n++;
        end
        return n;
    endfunction

    // Check each result word, then predict the word accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word: channel=%0d no_res=%0b fired=%b",
                                 result.channel, result.no_resources, result.fired_mask);
                    mismatches++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (result.channel !== oldest_result.channel ||
                        result.no_resources !== oldest_result.no_resources ||
                        result.fired_mask !== oldest_result.fired_mask)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: expected channel=%0d no_res=%0b fired=%b,",
                                      " got channel=%0d no_res=%0b fired=%b"},
                                     oldest_result.channel, oldest_result.no_resources,
                                     oldest_result.fired_mask, result.channel,
                                     result.no_resources, result.fired_mask);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(timer_step(request));
                words_accepted++;
            end
        end
    end

    // Drive one word from a falling edge and hold it until accepted
    task automatic send_word(input op_t op, input logic [TICKS_WIDTH-1:0] t);
        int n;
        n                 = words_accepted;
        start             = 1'b1;
        request.operation = op;
        request.ticks     = t;
        do
            @(negedge clk);
        while (words_accepted == n);
    endtask

    task automatic idle_gap(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // First tick after reset: counter leaves zero, nothing armed
    task automatic test_reset_tick();
        send_word(OP_TICK, '0);
        idle_gap(2);
    endtask

    // Fill every channel with each kind of request, then overflow
    task automatic test_channel_allocation();
        send_word(OP_REPEAT, 32'd3);
        send_word(OP_ABS_ONESHOT, tmr_count + 32'd2);
        send_word(OP_REL_ONESHOT, 32'd1);
        send_word(OP_REL_ONESHOT, 32'd3);
        send_word(OP_ABS_ONESHOT, 32'hFFFF_FFFF);
        send_word(OP_REL_ONESHOT, 32'h0000_0000);
        send_word(OP_REPEAT, 32'hFFFF_FFFF);
        idle_gap(1);
    endtask

    // Tick through single and joint matches, then reuse a freed channel
    task automatic test_compare_fire();
        send_word(OP_TICK, 32'hFFFF_FFFF);
        send_word(OP_TICK, 32'h0000_0000);
        send_word(OP_TICK, 32'hA5A5_A5A5);
        send_word(OP_TICK, 32'h5A5A_5A5A);
        send_word(OP_REL_ONESHOT, 32'd2);
        idle_gap(3);
        send_word(OP_TICK, '0);
        send_word(OP_TICK, '0);
        send_word(OP_TICK, '0);
        idle_gap(1);
    endtask

    // Mix ticks and short one-shots in bursts; full-range ticks on overflow
    task automatic test_random_traffic(input int n_words);
        int                     sent;
        int                     burst;
        int                     k;
        op_t                    op;
        logic [TICKS_WIDTH-1:0] t;
        sent = 0;
        while (sent < n_words)
        begin
            burst = $urandom_range(1, 16);
            for (k = 0; k < burst && sent < n_words; k++)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    op = OP_TICK;
                    t  = $urandom;
                end
                else
                begin
                    op = op_t'($urandom_range(1, 3));
                    if (free_channel_count() == 0)
                        t = $urandom;
                    else
                    begin
                        // Repeating channels never free up: keep them out of the pool
                        if (op == OP_REPEAT)
                            op = OP_REL_ONESHOT;
                        if (op == OP_ABS_ONESHOT)
                            t = tmr_count + TICKS_WIDTH'($urandom_range(1, MAX_DELAY));
                        else
                            t = TICKS_WIDTH'($urandom_range(1, MAX_DELAY));
                    end
                end
                send_word(op, t);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 6));
        end
    endtask

    // Arm compares at or just behind the count, and one far ahead of it
    task automatic test_unreachable_compares();
        int k;
        for (k = 0; k < 2 * MAX_DELAY + 8 && free_channel_count() < NUM_CH - 1; k++)
            send_word(OP_TICK, '0);
        send_word(OP_REL_ONESHOT, 32'd0);
        send_word(OP_ABS_ONESHOT, tmr_count - 1'b1);
        send_word(OP_REPEAT, 32'd0);
        send_word(OP_ABS_ONESHOT, 32'h8000_0000);
        idle_gap(2);
        repeat (8) send_word(OP_TICK, '0);
        idle_gap(1);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        tmr_count      = '0;
        chan_armed     = '0;
        chan_repeats   = '0;
        words_accepted = 0;
        mismatches     = 0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            chan_period[c]  = '0;
            chan_compare[c] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_tick();
        test_channel_allocation();
        test_compare_fire();
        test_random_traffic(RANDOM_WORDS);
        test_unreachable_compares();

        // Drain outstanding results, then allow the pipeline to settle
        start        = 1'b0;
        drain_cycles = 0;
        while (expected_results.size() != 0 && drain_cycles < 100)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (4) @(negedge clk);
        if (expected_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
